@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the SpMV RTL files.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define SMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SMV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/smv_pkg.sv @@
// Shared types and constants for the CSR sparse matrix-vector multiply unit.
// No dependencies; imported by the top unit, smv_row_acc and the bench (smv_vec_mem does not use it).
package smv_pkg;

    localparam int unsigned IDX_W     = 12;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned ACC_W     = 48;
    localparam int unsigned ROW_W     = 16;
    localparam int unsigned LEN_W     = 13;
    localparam int unsigned ACT_W     = 2;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned M_TUSER_W = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;
    localparam logic [VAL_W-1:0] SUM_MAX   = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SUM_MIN   = 32'h8000_0000;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TERM  = 2'd1,
        ACT_EMPTY = 2'd2
    } t_action;

    // One term or empty-row beat handed to the accumulator stage.
    typedef struct packed {
        logic             empty;
        logic             last;
        logic             col_err;
        logic [ACC_W-1:0] term;
    } t_beat;

endpackage

@@ hw/rtl/smv_vec_mem.sv @@
// Vector store: single write port, single synchronous (registered) read port.
// Standalone; uses no package items.
module smv_vec_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned DATA_W = 32,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next read so a stalled consumer keeps its operand.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/smv_row_acc.sv @@
// Row accumulator stage: 48-bit sum, row close with saturation, row counter, output register.
// Depends on smv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smv_row_acc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_beat_valid,
    input  smv_pkg::t_beat             i_beat,
    output logic                       o_beat_ready,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [smv_pkg::VAL_W-1:0]  o_out_sum,
    output logic [smv_pkg::ROW_W-1:0]  o_out_row,
    output logic                       o_out_sat,
    output logic                       o_out_err
);

    import smv_pkg::*;

    logic             r_s2_valid;
    t_beat            r_s2;
    logic [ACC_W-1:0] r_acc;
    logic             r_err;
    logic [ROW_W-1:0] r_row_cnt;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_sum;
    logic [ROW_W-1:0] r_out_row;
    logic             r_out_sat;
    logic             r_out_err;

    logic             w_out_free;
    logic             w_emits;
    logic             w_s2_go;
    logic [ACC_W-1:0] w_sum;
    logic             w_err;
    logic             w_sat;
    logic [VAL_W-1:0] w_clip;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_emits      = r_s2.empty || r_s2.last;
    assign w_s2_go      = r_s2_valid && (!w_emits || w_out_free);
    assign o_beat_ready = !r_s2_valid || w_s2_go;

    assign w_sum = r_acc + r_s2.term;
    assign w_err = r_err | r_s2.col_err;
    // Clip when the bits above the 32-bit sign do not all match it.
    assign w_sat  = (w_sum[ACC_W-1:VAL_W-1] != '0) && (w_sum[ACC_W-1:VAL_W-1] != '1);
    assign w_clip = w_sat ? (w_sum[ACC_W-1] ? SUM_MIN : SUM_MAX) : w_sum[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_row_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_beat_ready) begin
                r_s2_valid <= i_beat_valid;
            end
            if (w_s2_go && w_emits) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_s2_go) begin
                if (r_s2.empty) begin
                    r_row_cnt <= r_row_cnt + 1'b1;
                end else if (r_s2.last) begin
                    r_acc     <= '0;
                    r_err     <= 1'b0;
                    r_row_cnt <= r_row_cnt + 1'b1;
                end else begin
                    r_acc <= w_sum;
                    r_err <= w_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_beat_ready && i_beat_valid) begin
            r_s2 <= i_beat;
        end
        if (w_s2_go && w_emits) begin
            r_out_row <= r_row_cnt;
            if (r_s2.empty) begin
                r_out_sum <= '0;
                r_out_sat <= 1'b0;
                r_out_err <= 1'b0;
            end else begin
                r_out_sum <= w_clip;
                r_out_sat <= w_sat;
                r_out_err <= w_err;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_sum   = r_out_sum;
    assign o_out_row   = r_out_row;
    assign o_out_sat   = r_out_sat;
    assign o_out_err   = r_out_err;

    `SMV_ASSERT(a_close_clears, (w_s2_go && !r_s2.empty && r_s2.last) |=> (r_acc == '0 && !r_err), "row close did not clear the accumulator")
    `SMV_ASSERT(a_row_step, (w_s2_go && w_emits) |=> (r_row_cnt == ROW_W'($past(r_row_cnt) + 1'b1)), "row counter did not advance on emit")
    `SMV_ASSERT(a_sat_bound, (r_out_valid && r_out_sat) |-> (r_out_sum == SUM_MAX || r_out_sum == SUM_MIN), "saturated sum is not a bound")
    `SMV_ASSERT(a_no_drop, (r_out_valid && !i_out_ready) |=> r_out_valid, "pending result dropped")

endmodule

@@ hw/rtl/csr_sparse_matrix_vector_multiply_unit.sv @@
// CSR sparse matrix-vector multiply, y = A*x, in signed Q16.16. Depends on smv_pkg, smv_vec_mem,
// smv_row_acc and assert_macros.svh. Beat kinds: a load (tuser 0) writes
// x[index] into the vector store, a term (tuser 1) reads x[index] from the store's single read
// port, multiplies it with the nonzero in a 32x32 multiplier and adds the product, truncated to
// Q16.16, into a 48-bit accumulator; tlast on a term closes the row. An empty-row beat (tuser 2)
// yields a zero sum. One beat per cycle is sustained while the output is not stalled, bounded by
// the one memory port and the one multiplier; a result passes the stage-1 and stage-2 registers
// to the output register. A waiting result does not block the pipe until all three stages are
// full. vector_length may be written only while the unit is idle. The vector store has no reset;
// read only entries that were loaded. There is no clearing pass after reset.
`include "assert_macros.svh"

module csr_sparse_matrix_vector_multiply_unit #(
    parameter int unsigned VECTOR_DEPTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [smv_pkg::LEN_W-1:0]      i_cfg_wr_data,   // vector_length
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [smv_pkg::S_TDATA_W-1:0]  i_s_tdata,       // [11:0] index, [43:12] value
    input  logic                           i_s_tlast,       // row_end
    input  logic [smv_pkg::ACT_W-1:0]      i_s_tuser,       // [1:0] action
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [smv_pkg::M_TDATA_W-1:0]  o_m_tdata,       // [31:0] row_sum, [47:32] row_number
    output logic [smv_pkg::M_TUSER_W-1:0]  o_m_tuser        // [0] saturated, [1] column_error
);

    import smv_pkg::*;

    localparam int unsigned ADDR_W = $clog2(VECTOR_DEPTH);
    localparam int unsigned WIDE_W = IDX_W + ADDR_W;

    logic [LEN_W-1:0]  r_vec_len;
    logic              r_s1_valid;
    logic              r_s1_empty;
    logic              r_s1_last;
    logic              r_s1_in_range;
    logic [VAL_W-1:0]  r_s1_value;

    logic [IDX_W-1:0]  w_index;
    logic [VAL_W-1:0]  w_value;
    logic [WIDE_W-1:0] w_idx_wide;
    logic [ADDR_W-1:0] w_addr;
    logic              w_in_depth;
    logic              w_in_range;
    logic              w_accept;
    logic              w_is_load;
    logic              w_is_term;
    logic              w_is_empty;
    logic              w_s1_go;
    logic              w_beat_ready;
    logic [VAL_W-1:0]  w_rd_data;
    logic signed [2*VAL_W-1:0] w_prod;
    t_beat             w_beat;

    logic              w_out_valid;
    logic [VAL_W-1:0]  w_out_sum;
    logic [ROW_W-1:0]  w_out_row;
    logic              w_out_sat;
    logic              w_out_err;

    assign w_index    = i_s_tdata[IDX_W-1:0];
    assign w_value    = i_s_tdata[IDX_W+VAL_W-1:IDX_W];
    assign w_idx_wide = {{ADDR_W{1'b0}}, w_index};
    assign w_addr     = w_idx_wide[ADDR_W-1:0];
    assign w_in_depth = w_idx_wide < WIDE_W'(VECTOR_DEPTH);
    assign w_in_range = w_in_depth && ({1'b0, w_index} < r_vec_len);

    always_comb begin
        w_is_load  = 1'b0;
        w_is_term  = 1'b0;
        w_is_empty = 1'b0;
        case (t_action'(i_s_tuser))
            ACT_LOAD:  w_is_load  = 1'b1;
            ACT_TERM:  w_is_term  = 1'b1;
            ACT_EMPTY: w_is_empty = 1'b1;
            default:   w_is_load  = 1'b0;
        endcase
    end

    assign w_s1_go    = r_s1_valid && w_beat_ready;
    assign o_s_tready = !r_s1_valid || w_s1_go;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len  <= LEN_RESET;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vec_len <= i_cfg_wr_data;
            end
            // Loads and unused codes end here; only terms and empty rows move on.
            if (o_s_tready) begin
                r_s1_valid <= w_accept && (w_is_term || w_is_empty);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_empty    <= w_is_empty;
            r_s1_last     <= i_s_tlast;
            r_s1_in_range <= w_in_range;
            r_s1_value    <= w_value;
        end
    end

    smv_vec_mem #(
        .DEPTH  (VECTOR_DEPTH),
        .DATA_W (VAL_W)
    ) u_vec_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && w_is_load && w_in_depth),
        .i_wr_addr (w_addr),
        .i_wr_data (w_value),
        .i_rd_en   (w_accept && w_is_term),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_prod = $signed(r_s1_value) * $signed(w_rd_data);

    always_comb begin
        w_beat.empty   = r_s1_empty;
        w_beat.last    = r_s1_last;
        w_beat.col_err = !r_s1_empty && !r_s1_in_range;
        // Drop the 16 fraction bits below Q16.16; out-of-range columns add nothing.
        w_beat.term    = (r_s1_in_range && !r_s1_empty) ? w_prod[2*VAL_W-1:16] : '0;
    end

    smv_row_acc u_row_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (r_s1_valid),
        .i_beat       (w_beat),
        .o_beat_ready (w_beat_ready),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (w_out_valid),
        .o_out_sum    (w_out_sum),
        .o_out_row    (w_out_row),
        .o_out_sat    (w_out_sat),
        .o_out_err    (w_out_err)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {w_out_row, w_out_sum};
    assign o_m_tuser  = {w_out_err, w_out_sat};

    `SMV_ASSERT(a_s1_fill, (w_accept && (w_is_term || w_is_empty)) |=> r_s1_valid, "accepted beat lost before the multiply stage")
    `SMV_ASSERT(a_empty_no_err, (r_s1_valid && r_s1_empty) |-> (!w_beat.col_err && w_beat.term == '0), "empty row carries a term")

endmodule

@@ bench/csr_sparse_matrix_vector_multiply_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for csr_sparse_matrix_vector_multiply_unit: streams vector loads, CSR
// terms and empty rows through the block and checks every row sum against a built-in predictor.
// Depends on smv_pkg and the unit's RTL only.
module csr_sparse_matrix_vector_multiply_unit_tb;
    import smv_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;
    localparam int unsigned      CYCLE_LIMIT = 1_000_000;
    localparam int               SHOW_LIMIT  = 50;

    typedef struct {
        logic [VAL_W-1:0] sum;
        logic [ROW_W-1:0] row;
        logic             sat;
        logic             col_err;
    } t_row_result;

    // Predicts row sums from accepted beats and checks the output beats in order.
    class row_sum_scoreboard;
        logic [VAL_W-1:0] x_store [4096];
        logic [ACC_W-1:0] acc;
        logic [ROW_W-1:0] row_cnt;
        logic             row_err;
        logic [LEN_W-1:0] vec_len;
        t_row_result      expected_rows [$];
        int               errors;
        int               rows_checked;
        int               sat_rows;
        int               err_rows;

        function new();
            acc = '0;
            row_cnt = '0;
            row_err = 1'b0;
            vec_len = LEN_RESET;
            errors = 0;
            rows_checked = 0;
            sat_rows = 0;
            err_rows = 0;
        endfunction

        function void set_length(logic [LEN_W-1:0] len);
            vec_len = len;
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        function void push_row(logic [VAL_W-1:0] sum, logic sat, logic col_err);
            t_row_result r;
            r.sum = sum;
            r.row = row_cnt;
            r.sat = sat;
            r.col_err = col_err;
            expected_rows.push_back(r);
            row_cnt = row_cnt + 1'b1;
        endfunction

        function void note_beat(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                logic [VAL_W-1:0] val, logic last);
            longint prod;
            longint s;
            logic   sat;
            case (act)
                ACT_LOAD: begin
                    x_store[idx] = val;
                end
                ACT_EMPTY: begin
                    // partial sum of an open row survives an empty row
                    push_row('0, 1'b0, 1'b0);
                end
                ACT_TERM: begin
                    if ({1'b0, idx} < vec_len) begin
                        prod = longint'($signed(val)) * longint'($signed(x_store[idx]));
                        prod = prod >>> 16;
                        acc = acc + prod[ACC_W-1:0];
                    end else begin
                        row_err = 1'b1;
                    end
                    if (last) begin
                        s = $signed(acc);
                        sat = 1'b0;
                        if (s > 64'sd2147483647) begin
                            s = 64'sd2147483647;
                            sat = 1'b1;
                        end else if (s < -64'sd2147483648) begin
                            s = -64'sd2147483648;
                            sat = 1'b1;
                        end
                        push_row(s[VAL_W-1:0], sat, row_err);
                        acc = '0;
                        row_err = 1'b0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            end
        endfunction

        function void check_row(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            t_row_result want;
            if (expected_rows.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $error("row_number: expected no beat, actual 0x%0h", data[47:32]);
                return;
            end
            want = expected_rows.pop_front();
            check_field("row_sum", want.sum, data[31:0]);
            check_field("row_number", {16'd0, want.row}, {16'd0, data[47:32]});
            check_field("saturated", {31'd0, want.sat}, {31'd0, user[0]});
            check_field("column_error", {31'd0, want.col_err}, {31'd0, user[1]});
            rows_checked++;
            if (want.sat) sat_rows++;
            if (want.col_err) err_rows++;
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]     i_cfg_wr_data = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;     // [11:0] index, [43:12] value
    logic                 i_s_tlast = 1'b0;
    logic [ACT_W-1:0]     i_s_tuser = '0;     // [1:0] action
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;          // [31:0] row_sum, [47:32] row_number
    logic [M_TUSER_W-1:0] o_m_tuser;          // [0] saturated, [1] column_error

    row_sum_scoreboard sb;
    int unsigned       cycle_count = 0;
    int                hold_left = 0;
    int                sink_stall_pct = 0;
    int                src_idle_pct = 0;
    int                items_sent = 0;
    int                cur_len = 4096;
    bit                x_loaded [4096];
    int                loaded_list [$];

    csr_sparse_matrix_vector_multiply_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        i_m_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_row(o_m_tdata, o_m_tuser);
    end

    task automatic send_beat(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                             logic [VAL_W-1:0] val, logic last);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, val, idx};
        i_s_tlast  <= last;
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_beat(act, idx, val, last);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic load_x(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val, logic last);
        send_beat(ACT_LOAD, idx, val, last);
        if (!x_loaded[idx]) begin
            x_loaded[idx] = 1'b1;
            loaded_list.push_back(int'(idx));
        end
    endtask

    // drop valid, wait out every expected row, then let the pipe empty
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] len);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_length(len);
        cur_len = int'(len);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        int v;
        case ($urandom_range(9))
            0: return $urandom_range(1) ? SUM_MAX : SUM_MIN;
            1, 2, 3: return $urandom;
            default: begin
                v = int'($urandom_range(524288)) - 262144;   // within +-4.0
                return VAL_W'(v);
            end
        endcase
    endfunction

    // Only loaded entries or out-of-range columns: no unwritten entry is used in a sum.
    function automatic logic [IDX_W-1:0] pick_column();
        int r;
        int c;
        int k;
        r = $urandom_range(99);
        if (r < 8 && cur_len < 4096)
            return IDX_W'($urandom_range(4095, cur_len));
        if (r < 14) begin
            c = $urandom_range(4095);
            if (x_loaded[c] || c >= cur_len)
                return IDX_W'(c);
        end
        for (k = 0; k < 4; k++) begin
            c = loaded_list[$urandom_range(loaded_list.size() - 1)];
            if (c < cur_len)
                break;
        end
        return IDX_W'(c);
    endfunction

    task automatic run_random(int n_beats);
        int target;
        int n;
        int r;
        int k;
        target = items_sent + n_beats;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 12) begin
                load_x(IDX_W'($urandom_range(1) ? $urandom_range(63) : $urandom_range(4095)),
                       rand_value(), 1'($urandom_range(1)));
            end else if (r < 18) begin
                send_beat(ACT_EMPTY, IDX_W'($urandom), $urandom, 1'($urandom_range(1)));
            end else if (r < 21) begin
                send_beat(ACT_UNUSED, IDX_W'($urandom), $urandom, 1'($urandom_range(1)));
            end else if (r < 25) begin
                // leave the row open across whatever comes next
                send_beat(ACT_TERM, pick_column(), rand_value(), 1'b0);
            end else begin
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
                for (k = 0; k < n; k++)
                    send_beat(ACT_TERM, pick_column(), rand_value(), k == n - 1);
            end
        end
    endtask

    initial begin
        int ph;
        int k;
        int src_idle [4];
        int sink_stall [4];
        logic [LEN_W-1:0] phase_len [4];

        sb = new();
        src_idle   = '{0, 66, 0, 33};
        sink_stall = '{0, 0, 66, 33};
        phase_len[0] = 13'd8191;
        phase_len[1] = LEN_W'($urandom_range(4094, 2));
        phase_len[2] = 13'd4095;
        phase_len[3] = LEN_W'($urandom_range(64, 1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes at the reset length
        load_x(12'd0, SUM_MAX, 1'b0);
        load_x(12'd4095, SUM_MIN, 1'b0);
        load_x(12'd1, 32'h0001_0000, 1'b1);         // row end on a load is ignored
        load_x(12'd2, 32'hFFFF_FFFF, 1'b0);
        send_beat(ACT_TERM, 12'd0, SUM_MAX, 1'b1);     // clip high
        send_beat(ACT_TERM, 12'd4095, SUM_MAX, 1'b1);  // clip low
        send_beat(ACT_TERM, 12'd4095, SUM_MIN, 1'b1);
        send_beat(ACT_TERM, 12'd2, 32'h0000_0001, 1'b1); // truncation toward minus infinity
        send_beat(ACT_TERM, 12'd1, 32'h0001_8000, 1'b0);
        send_beat(ACT_EMPTY, 12'd0, '0, 1'b0);          // empty row inside an open row
        send_beat(ACT_UNUSED, 12'd5, 32'h1234_5678, 1'b1);
        send_beat(ACT_TERM, 12'd1, 32'hFFFF_0000, 1'b1);
        send_beat(ACT_TERM, 12'd0, 32'h0000_0000, 1'b1);
        // accumulator wraps modulo 2^48
        send_beat(ACT_TERM, 12'd0, SUM_MAX, 1'b0);
        send_beat(ACT_TERM, 12'd0, SUM_MAX, 1'b0);
        send_beat(ACT_TERM, 12'd0, SUM_MAX, 1'b1);
        drain();
        write_length(13'd1);
        send_beat(ACT_TERM, 12'd1, 32'h0001_0000, 1'b0);  // out-of-range column
        send_beat(ACT_TERM, 12'd0, 32'h0001_0000, 1'b1);
        drain();
        write_length(13'd0);
        send_beat(ACT_TERM, 12'd0, 32'h0000_0001, 1'b1);
        drain();
        write_length(13'd8191);
        send_beat(ACT_TERM, 12'd4095, 32'h0001_0000, 1'b1);
        send_beat(ACT_EMPTY, 12'd4095, 32'hFFFF_FFFF, 1'b1);
        drain();

        for (ph = 0; ph < 4; ph++) begin
            src_idle_pct = src_idle[ph];
            sink_stall_pct <= sink_stall[ph];
            write_length(phase_len[ph]);
            run_random(215);
            drain();
        end

        // hold the receiver off while beats keep coming, so the input backs up
        src_idle_pct = 0;
        sink_stall_pct <= 33;
        write_length(13'd4096);
        hold_left <= 400;
        for (k = 0; k < 80; k++) begin
            if (k % 2 == 0)
                send_beat(ACT_EMPTY, IDX_W'($urandom), $urandom, 1'b0);
            else
                send_beat(ACT_TERM, pick_column(), rand_value(), 1'b1);
        end
        drain();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d beats, checked %0d row sums (%0d clipped, %0d with bad columns).",
                 items_sent, sb.rows_checked, sb.sat_rows, sb.err_rows);
        $display("Lengths 0, 1, 4095, 4096, 8191 and random; idle mixes %s",
                 "on both sides and one long receiver hold-off.");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
